### rtl/flss_pkg.sv
// Shared types, widths, register indexes and reset values for the
// force-limited stroke sequencer. No dependencies.
package flss_pkg;

  localparam int POS_WIDTH   = 16;
  localparam int FORCE_WIDTH = 16;
  localparam int WAIT_WIDTH  = 16;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int DLIM_W     = 16;
  localparam int FLIM_W     = 15;
  localparam int WT_W       = 16;
  localparam int TOL_W      = 15;
  localparam int MSPD_W     = 15;
  localparam int ZF_W       = 16;
  localparam int SPD_W      = 16;
  localparam int PHASE_W    = 2;

  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION_LEFT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DISTANCE_LIMIT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FORCE_LIMIT      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WAIT_TICKS       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HOME_TOLERANCE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED        = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_SPEED_FORCE = 3'd6;

  localparam logic              RST_DIRECTION_LEFT   = 1'b0;
  localparam logic [DLIM_W-1:0] RST_DISTANCE_LIMIT   = 16'd3000;
  localparam logic [FLIM_W-1:0] RST_FORCE_LIMIT      = 15'd600;
  localparam logic [WT_W-1:0]   RST_WAIT_TICKS       = 16'd30;
  localparam logic [TOL_W-1:0]  RST_HOME_TOLERANCE   = 15'd200;
  localparam logic [MSPD_W-1:0] RST_MAX_SPEED        = 15'd1000;
  localparam logic [ZF_W-1:0]   RST_ZERO_SPEED_FORCE = 16'd600;

  // derived datapath widths and iteration counts
  localparam int DIST_W   = POS_WIDTH + 1;
  localparam int SQ_W     = 2 * POS_WIDTH + 2;
  localparam int RR_W     = DIST_W + 3;
  localparam int FSUM_W   = FORCE_WIDTH + 1;
  localparam int MAG_W    = (FSUM_W > ZF_W) ? FSUM_W : ZF_W;
  localparam int MUL_W    = (POS_WIDTH > MAG_W) ? POS_WIDTH : MAG_W;
  localparam int NUM_W    = MSPD_W + MAG_W;
  localparam int ITER_N   = (NUM_W > DIST_W) ? NUM_W : DIST_W;
  localparam int CNT_W    = $clog2(ITER_N);
  localparam int PCMP_W   = (POS_WIDTH > TOL_W) ? POS_WIDTH : TOL_W;
  localparam int FCMP_W   = (FORCE_WIDTH > FLIM_W) ? FORCE_WIDTH : FLIM_W;
  localparam int DCMP_W   = (DIST_W > DLIM_W) ? DIST_W : DLIM_W;
  localparam int WCMP_W   = (WAIT_WIDTH > WT_W) ? WAIT_WIDTH : WT_W;
  localparam int MUL_STEPS = 4;

  typedef enum logic [1:0] {
    PH_FWD  = 2'd0,
    PH_WAIT = 2'd1,
    PH_BACK = 2'd2,
    PH_STOP = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    CMD_ZERO = 2'd0,
    CMD_FWD  = 2'd1,
    CMD_BACK = 2'd2
  } cmd_mode_e;

  typedef enum logic [1:0] {
    MUL_SQ_X  = 2'd0,
    MUL_SQ_Y  = 2'd1,
    MUL_SQ_Z  = 2'd2,
    MUL_SPEED = 2'd3
  } mul_sel_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_INIT,
    ST_ITER,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic              direction_left;
    logic [DLIM_W-1:0] distance_limit;
    logic [FLIM_W-1:0] force_limit;
    logic [WT_W-1:0]   wait_ticks;
    logic [TOL_W-1:0]  home_tolerance;
    logic [MSPD_W-1:0] max_speed;
    logic [ZF_W-1:0]   zero_speed_force;
  } cfg_t;

  typedef struct packed {
    logic      load_in;
    logic      latch_origin;
    logic      mul_en;
    mul_sel_e  mul_sel;
    logic      acc_en;
    logic      iter_init;
    logic      div_step;
    logic      root_step;
    logic      out_load;
    cmd_mode_e cmd_mode;
    logic      sent;
    phase_e    phase;
  } dp_cmd_t;

  typedef struct packed {
    logic dist_reached;
    logic force_over;
    logic at_home;
  } dp_stat_t;

endpackage

### rtl/flss_cfg.sv
// Configuration register file for the stroke sequencer.
// Depends on flss_pkg.
module flss_cfg import flss_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.direction_left   <= RST_DIRECTION_LEFT;
      cfg_q.distance_limit   <= RST_DISTANCE_LIMIT;
      cfg_q.force_limit      <= RST_FORCE_LIMIT;
      cfg_q.wait_ticks       <= RST_WAIT_TICKS;
      cfg_q.home_tolerance   <= RST_HOME_TOLERANCE;
      cfg_q.max_speed        <= RST_MAX_SPEED;
      cfg_q.zero_speed_force <= RST_ZERO_SPEED_FORCE;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DIRECTION_LEFT:   cfg_q.direction_left   <= cfg_data_i[0];
        REG_DISTANCE_LIMIT:   cfg_q.distance_limit   <= cfg_data_i[DLIM_W-1:0];
        REG_FORCE_LIMIT:      cfg_q.force_limit      <= cfg_data_i[FLIM_W-1:0];
        REG_WAIT_TICKS:       cfg_q.wait_ticks       <= cfg_data_i[WT_W-1:0];
        REG_HOME_TOLERANCE:   cfg_q.home_tolerance   <= cfg_data_i[TOL_W-1:0];
        REG_MAX_SPEED:        cfg_q.max_speed        <= cfg_data_i[MSPD_W-1:0];
        REG_ZERO_SPEED_FORCE: cfg_q.zero_speed_force <= cfg_data_i[ZF_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/flss_ctrl.sv
// Controller: sequences one tick through the datapath, owns the phase,
// wait counter, origin flag and the handshakes. Depends on flss_pkg.
module flss_ctrl import flss_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  logic     pose_valid_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  state_e                state_q, state_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  phase_e                phase_q, phase_d;
  logic [WAIT_WIDTH-1:0] wait_cnt_q, wait_cnt_d;
  logic                  origin_known_q, origin_known_d;
  logic                  out_valid_q, out_valid_d;
  logic [WAIT_WIDTH-1:0] wait_inc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      cnt_q          <= '0;
      phase_q        <= PH_FWD;
      wait_cnt_q     <= '0;
      origin_known_q <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      cnt_q          <= cnt_d;
      phase_q        <= phase_d;
      wait_cnt_q     <= wait_cnt_d;
      origin_known_q <= origin_known_d;
      out_valid_q    <= out_valid_d;
    end
  end

  assign wait_inc = (wait_cnt_q == '1) ? wait_cnt_q : wait_cnt_q + 1'b1;

  always_comb begin
    state_d        = state_q;
    cnt_d          = cnt_q;
    phase_d        = phase_q;
    wait_cnt_d     = wait_cnt_q;
    origin_known_d = origin_known_q;
    out_valid_d    = out_valid_q && out_stall_i;
    cmd_o          = '0;
    cmd_o.mul_sel  = MUL_SQ_X;
    cmd_o.cmd_mode = CMD_ZERO;
    cmd_o.phase    = phase_q;
    in_stall_o     = (state_q != ST_IDLE);

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && pose_valid_i) begin
          cmd_o.load_in      = 1'b1;
          cmd_o.latch_origin = !origin_known_q;
          origin_known_d     = 1'b1;
          cnt_d              = '0;
          state_d            = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul_en  = (cnt_q < CNT_W'(MUL_STEPS));
        cmd_o.mul_sel = mul_sel_e'(cnt_q[1:0]);
        cmd_o.acc_en  = (cnt_q != '0);
        cnt_d         = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(MUL_STEPS)) begin
          state_d = ST_INIT;
        end
      end
      ST_INIT: begin
        cmd_o.iter_init = 1'b1;
        cnt_d           = '0;
        state_d         = ST_ITER;
      end
      ST_ITER: begin
        cmd_o.div_step  = ({1'b0, cnt_q} < (CNT_W+1)'(NUM_W));
        cmd_o.root_step = ({1'b0, cnt_q} < (CNT_W+1)'(DIST_W));
        cnt_d           = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(ITER_N - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
          case (phase_q)
            PH_FWD: begin
              cmd_o.sent = 1'b1;
              if (stat_i.dist_reached || stat_i.force_over) begin
                phase_d    = PH_WAIT;
                wait_cnt_d = '0;
              end else begin
                cmd_o.cmd_mode = CMD_FWD;
              end
            end
            PH_WAIT: begin
              wait_cnt_d = wait_inc;
              if (WCMP_W'(wait_inc) >= WCMP_W'(cfg_i.wait_ticks)) begin
                phase_d = PH_BACK;
              end
            end
            PH_BACK: begin
              cmd_o.sent = 1'b1;
              if (stat_i.at_home) begin
                phase_d = PH_STOP;
              end else begin
                cmd_o.cmd_mode = CMD_BACK;
              end
            end
            default: begin
              cmd_o.sent = 1'b1;
              phase_d    = PH_STOP;
            end
          endcase
          cmd_o.phase = phase_d;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

### rtl/flss_dp.sv
// Datapath: offsets and force magnitudes, shared multiplier, restoring
// divider and digit-by-digit root, and the result register. Depends on flss_pkg.
module flss_dp import flss_pkg::*; (
  input  logic                          clk_i,
  input  cfg_t                          cfg_i,
  input  dp_cmd_t                       cmd_i,
  input  logic signed [POS_WIDTH-1:0]   pos_x_i,
  input  logic signed [POS_WIDTH-1:0]   pos_y_i,
  input  logic signed [POS_WIDTH-1:0]   pos_z_i,
  input  logic signed [FORCE_WIDTH-1:0] force_x_i,
  input  logic signed [FORCE_WIDTH-1:0] force_y_i,
  input  logic signed [FORCE_WIDTH-1:0] force_z_i,
  output dp_stat_t                      stat_o,
  output logic [DIST_W-1:0]             distance_o,
  output logic signed [SPD_W-1:0]       speed_cmd_o,
  output logic                          speed_cmd_sent_o,
  output logic [PHASE_W-1:0]            phase_o
);

  function automatic logic [POS_WIDTH-1:0] abs_diff(
    input logic signed [POS_WIDTH-1:0] a,
    input logic signed [POS_WIDTH-1:0] b
  );
    logic signed [POS_WIDTH:0] d;
    logic signed [POS_WIDTH:0] m;
    d = {a[POS_WIDTH-1], a} - {b[POS_WIDTH-1], b};
    m = d[POS_WIDTH] ? -d : d;
    return m[POS_WIDTH-1:0];
  endfunction

  function automatic logic [FORCE_WIDTH-1:0] abs_frc(
    input logic signed [FORCE_WIDTH-1:0] f
  );
    logic [FORCE_WIDTH-1:0] m;
    m = f[FORCE_WIDTH-1] ? (~f + 1'b1) : f;
    return m;
  endfunction

  logic signed [POS_WIDTH-1:0] org_x_q, org_y_q, org_z_q;
  logic signed [POS_WIDTH-1:0] base_x, base_y, base_z;
  logic [POS_WIDTH-1:0]        ax_q, ay_q, az_q;
  logic [FORCE_WIDTH-1:0]      fax_q, fay_q, faz_q;

  logic [FSUM_W-1:0]       fsum;
  logic [ZF_W-1:0]         zf;
  logic signed [MAG_W:0]   sdiff;
  logic signed [MAG_W:0]   sdiff_abs;
  logic [MAG_W-1:0]        mag_q;
  logic                    neg_q;

  logic [MUL_W-1:0]        op_a, op_b;
  logic [2*MUL_W-1:0]      prod_q;
  mul_sel_e                prod_sel_q;
  logic [SQ_W-1:0]         sq_q;
  logic [NUM_W-1:0]        num_q;

  logic [SQ_W-1:0]         rad_q;
  logic [RR_W-1:0]         rr_q;
  logic [RR_W-1:0]         rr_sh;
  logic [RR_W-1:0]         trial;
  logic [DIST_W-1:0]       root_q;

  logic [NUM_W-1:0]        dvd_q;
  logic [NUM_W-1:0]        quo_q;
  logic [ZF_W-1:0]         rem_q;
  logic [ZF_W:0]           dtry;
  logic [ZF_W:0]           dsub;

  logic [NUM_W:0]          spd_mag;
  logic                    cmd_neg;
  logic [SPD_W-1:0]        spd_val;

  logic [DIST_W-1:0]       dist_q;
  logic [SPD_W-1:0]        spd_q;
  logic                    sent_q;
  logic [PHASE_W-1:0]      phase_q;

  // input capture; origin follows the first valid pose
  assign base_x = cmd_i.latch_origin ? pos_x_i : org_x_q;
  assign base_y = cmd_i.latch_origin ? pos_y_i : org_y_q;
  assign base_z = cmd_i.latch_origin ? pos_z_i : org_z_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_origin) begin
      org_x_q <= pos_x_i;
      org_y_q <= pos_y_i;
      org_z_q <= pos_z_i;
    end
    if (cmd_i.load_in) begin
      ax_q  <= abs_diff(pos_x_i, base_x);
      ay_q  <= abs_diff(pos_y_i, base_y);
      az_q  <= abs_diff(pos_z_i, base_z);
      fax_q <= abs_frc(force_x_i);
      fay_q <= abs_frc(force_y_i);
      faz_q <= abs_frc(force_z_i);
    end
  end

  // speed law operand: max_speed * |Z - F|, sign kept apart
  assign fsum      = FSUM_W'(fax_q) + FSUM_W'(fay_q);
  assign zf        = (cfg_i.zero_speed_force == '0) ? ZF_W'(1) : cfg_i.zero_speed_force;
  assign sdiff     = $signed((MAG_W+1)'(zf)) - $signed((MAG_W+1)'(fsum));
  assign sdiff_abs = sdiff[MAG_W] ? -sdiff : sdiff;

  always_ff @(posedge clk_i) begin
    mag_q <= sdiff_abs[MAG_W-1:0];
    neg_q <= sdiff[MAG_W];
  end

  // shared multiplier
  always_comb begin
    case (cmd_i.mul_sel)
      MUL_SQ_X: begin
        op_a = MUL_W'(ax_q);
        op_b = MUL_W'(ax_q);
      end
      MUL_SQ_Y: begin
        op_a = MUL_W'(ay_q);
        op_b = MUL_W'(ay_q);
      end
      MUL_SQ_Z: begin
        op_a = MUL_W'(az_q);
        op_b = MUL_W'(az_q);
      end
      default: begin
        op_a = MUL_W'(mag_q);
        op_b = MUL_W'(cfg_i.max_speed);
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q     <= op_a * op_b;
      prod_sel_q <= cmd_i.mul_sel;
    end
    if (cmd_i.acc_en) begin
      case (prod_sel_q)
        MUL_SQ_X: sq_q  <= SQ_W'(prod_q[2*POS_WIDTH-1:0]);
        MUL_SQ_Y,
        MUL_SQ_Z: sq_q  <= sq_q + SQ_W'(prod_q[2*POS_WIDTH-1:0]);
        default:  num_q <= prod_q[NUM_W-1:0];
      endcase
    end
  end

  // root: two radicand bits per step
  assign rr_sh = {rr_q[RR_W-3:0], rad_q[SQ_W-1 -: 2]};
  assign trial = RR_W'({root_q, 2'b01});

  // divider: one quotient bit per step
  assign dtry = {rem_q, dvd_q[NUM_W-1]};
  assign dsub = dtry - (ZF_W+1)'(zf);

  always_ff @(posedge clk_i) begin
    if (cmd_i.iter_init) begin
      rad_q  <= sq_q;
      rr_q   <= '0;
      root_q <= '0;
      dvd_q  <= num_q;
      quo_q  <= '0;
      rem_q  <= '0;
    end else begin
      if (cmd_i.root_step) begin
        rad_q <= rad_q << 2;
        if (rr_sh >= trial) begin
          rr_q   <= rr_sh - trial;
          root_q <= {root_q[DIST_W-2:0], 1'b1};
        end else begin
          rr_q   <= rr_sh;
          root_q <= {root_q[DIST_W-2:0], 1'b0};
        end
      end
      if (cmd_i.div_step) begin
        dvd_q <= dvd_q << 1;
        if (dtry >= (ZF_W+1)'(zf)) begin
          rem_q <= dsub[ZF_W-1:0];
          quo_q <= {quo_q[NUM_W-2:0], 1'b1};
        end else begin
          rem_q <= dtry[ZF_W-1:0];
          quo_q <= {quo_q[NUM_W-2:0], 1'b0};
        end
      end
    end
  end

  // floor rounding toward minus infinity, direction, 16-bit saturation
  assign spd_mag = (NUM_W+1)'(quo_q) + (NUM_W+1)'(neg_q && (rem_q != '0));

  always_comb begin
    cmd_neg = neg_q ^ cfg_i.direction_left;
    spd_val = '0;
    case (cmd_i.cmd_mode)
      CMD_FWD:  cmd_neg = neg_q ^ cfg_i.direction_left;
      CMD_BACK: cmd_neg = neg_q ^ !cfg_i.direction_left;
      default:  cmd_neg = 1'b0;
    endcase
    if (cmd_i.cmd_mode == CMD_FWD || cmd_i.cmd_mode == CMD_BACK) begin
      if (cmd_neg) begin
        if (spd_mag > (NUM_W+1)'(2**(SPD_W-1))) begin
          spd_val = {1'b1, {(SPD_W-1){1'b0}}};
        end else begin
          spd_val = ~spd_mag[SPD_W-1:0] + 1'b1;
        end
      end else begin
        if (spd_mag > (NUM_W+1)'(2**(SPD_W-1) - 1)) begin
          spd_val = {1'b0, {(SPD_W-1){1'b1}}};
        end else begin
          spd_val = spd_mag[SPD_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      dist_q  <= root_q;
      spd_q   <= spd_val;
      sent_q  <= cmd_i.sent;
      phase_q <= cmd_i.phase;
    end
  end

  assign stat_o.dist_reached = (DCMP_W'(root_q) >= DCMP_W'(cfg_i.distance_limit));
  assign stat_o.force_over   = (FCMP_W'(fax_q) > FCMP_W'(cfg_i.force_limit)) ||
                               (FCMP_W'(fay_q) > FCMP_W'(cfg_i.force_limit)) ||
                               (FCMP_W'(faz_q) > FCMP_W'(cfg_i.force_limit));
  assign stat_o.at_home      = (PCMP_W'(ax_q) < PCMP_W'(cfg_i.home_tolerance)) &&
                               (PCMP_W'(ay_q) < PCMP_W'(cfg_i.home_tolerance)) &&
                               (PCMP_W'(az_q) < PCMP_W'(cfg_i.home_tolerance));

  assign distance_o       = dist_q;
  assign speed_cmd_o      = $signed(spd_q);
  assign speed_cmd_sent_o = sent_q;
  assign phase_o          = phase_q;

endmodule

### rtl/force_limited_stroke_sequencer_core.sv
// Top level of the force-limited stroke sequencer: config registers,
// controller and datapath. Depends on flss_pkg, flss_cfg, flss_ctrl, flss_dp.
//
// One transaction per control tick. A tick with pose_valid low is taken while
// the core is idle and gives no result. A valid tick occupies the core through
// these steps at default widths: the acceptance cycle that captures offsets and
// force magnitudes, the shared 17x17 multiplier for the three squares and the
// speed product, a setup state, then 32 steps of the restoring divider for the
// speed law, with the 17-step square root running alongside, and a last state
// that updates the phase and loads the result. The next tick is taken only once
// the result is loaded; in_stall_o stays high from acceptance until the result
// is loaded, longer while an earlier result still waits to be taken.
module force_limited_stroke_sequencer_core import flss_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]         cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          pose_valid_i,
  input  logic signed [POS_WIDTH-1:0]   pos_x_i,
  input  logic signed [POS_WIDTH-1:0]   pos_y_i,
  input  logic signed [POS_WIDTH-1:0]   pos_z_i,
  input  logic signed [FORCE_WIDTH-1:0] force_x_i,
  input  logic signed [FORCE_WIDTH-1:0] force_y_i,
  input  logic signed [FORCE_WIDTH-1:0] force_z_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [DIST_W-1:0]             distance_o,
  output logic signed [SPD_W-1:0]       speed_cmd_o,
  output logic                          speed_cmd_sent_o,
  output logic [PHASE_W-1:0]            phase_o
);

  cfg_t     cfg;
  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  flss_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  flss_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .pose_valid_i (pose_valid_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .stat_i       (dp_stat),
    .cmd_o        (dp_cmd)
  );

  flss_dp u_dp (
    .clk_i            (clk_i),
    .cfg_i            (cfg),
    .cmd_i            (dp_cmd),
    .pos_x_i          (pos_x_i),
    .pos_y_i          (pos_y_i),
    .pos_z_i          (pos_z_i),
    .force_x_i        (force_x_i),
    .force_y_i        (force_y_i),
    .force_z_i        (force_z_i),
    .stat_o           (dp_stat),
    .distance_o       (distance_o),
    .speed_cmd_o      (speed_cmd_o),
    .speed_cmd_sent_o (speed_cmd_sent_o),
    .phase_o          (phase_o)
  );

endmodule

### verif/flss_checker.sv
// Scoreboard for the stroke sequencer: mirrors the config writes, predicts one
// result per valid tick and compares each accepted result field by field.
// Depends on flss_pkg.
module flss_checker import flss_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]         cfg_data_i,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic                          pose_valid_i,
  input  logic signed [POS_WIDTH-1:0]   pos_x_i,
  input  logic signed [POS_WIDTH-1:0]   pos_y_i,
  input  logic signed [POS_WIDTH-1:0]   pos_z_i,
  input  logic signed [FORCE_WIDTH-1:0] force_x_i,
  input  logic signed [FORCE_WIDTH-1:0] force_y_i,
  input  logic signed [FORCE_WIDTH-1:0] force_z_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic [DIST_W-1:0]             distance_i,
  input  logic signed [SPD_W-1:0]       speed_cmd_i,
  input  logic                          speed_cmd_sent_i,
  input  logic [PHASE_W-1:0]            phase_i,
  output int                            fail_count_o,
  output int                            pending_o
);

  typedef struct packed {
    logic [DIST_W-1:0]       distance;
    logic signed [SPD_W-1:0] speed_cmd;
    logic                    sent;
    phase_e                  phase;
  } tick_result_t;

  tick_result_t                 tick_results_q[$];
  tick_result_t                 oldest;
  cfg_t                         cfg;
  phase_e                       seq_phase;
  logic                         origin_set;
  logic signed [POS_WIDTH-1:0]  org_x, org_y, org_z;
  logic [WAIT_WIDTH-1:0]        dwell_cnt;
  int                           n_fail = 0;

  function automatic longint unsigned mag(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint unsigned floor_sqrt(input longint unsigned n);
    longint unsigned rem, root, b;
    rem  = n;
    root = 0;
    b    = 64'd1 << 62;
    while (b > rem) b = b >> 2;
    while (b != 0) begin
      if (rem >= root + b) begin
        rem  = rem - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  function automatic tick_result_t predict_tick(
    input logic signed [POS_WIDTH-1:0]   px, py, pz,
    input logic signed [FORCE_WIDTH-1:0] fx, fy, fz
  );
    longint unsigned ax, ay, az, root_len, fsum;
    longint          zf, num, spd, cmd;
    logic            over;
    tick_result_t    r;
    if (!origin_set) begin
      org_x      = px;
      org_y      = py;
      org_z      = pz;
      origin_set = 1'b1;
    end
    ax   = mag(longint'(px) - longint'(org_x));
    ay   = mag(longint'(py) - longint'(org_y));
    az   = mag(longint'(pz) - longint'(org_z));
    root_len = floor_sqrt(ax * ax + ay * ay + az * az);

    fsum = mag(fx) + mag(fy);
    zf   = (cfg.zero_speed_force == 0) ? 1 : longint'(cfg.zero_speed_force);
    num  = longint'(cfg.max_speed) * (zf - longint'(fsum));
    spd  = num / zf;
    if (num < 0 && (num % zf) != 0) spd = spd - 1;
    if (spd > longint'(cfg.max_speed)) spd = longint'(cfg.max_speed);

    cmd    = 0;
    r.sent = 1'b0;
    case (seq_phase)
      PH_FWD: begin
        over = (mag(fx) > cfg.force_limit) || (mag(fy) > cfg.force_limit) ||
               (mag(fz) > cfg.force_limit);
        r.sent = 1'b1;
        if (root_len >= cfg.distance_limit || over) begin
          seq_phase = PH_WAIT;
          dwell_cnt = '0;
        end else begin
          cmd = cfg.direction_left ? -spd : spd;
        end
      end
      PH_WAIT: begin
        if (dwell_cnt != {WAIT_WIDTH{1'b1}}) dwell_cnt = dwell_cnt + 1'b1;
        if (dwell_cnt >= cfg.wait_ticks) seq_phase = PH_BACK;
      end
      PH_BACK: begin
        r.sent = 1'b1;
        if (ax < cfg.home_tolerance && ay < cfg.home_tolerance &&
            az < cfg.home_tolerance) begin
          seq_phase = PH_STOP;
        end else begin
          cmd = cfg.direction_left ? spd : -spd;
        end
      end
      default: begin
        seq_phase = PH_STOP;
        r.sent    = 1'b1;
      end
    endcase

    if (cmd > 32767) cmd = 32767;
    else if (cmd < -32768) cmd = -32768;
    r.distance  = root_len[DIST_W-1:0];
    r.speed_cmd = cmd[SPD_W-1:0];
    r.phase     = seq_phase;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg.direction_left   = RST_DIRECTION_LEFT;
      cfg.distance_limit   = RST_DISTANCE_LIMIT;
      cfg.force_limit      = RST_FORCE_LIMIT;
      cfg.wait_ticks       = RST_WAIT_TICKS;
      cfg.home_tolerance   = RST_HOME_TOLERANCE;
      cfg.max_speed        = RST_MAX_SPEED;
      cfg.zero_speed_force = RST_ZERO_SPEED_FORCE;
      seq_phase            = PH_FWD;
      origin_set           = 1'b0;
      org_x                = '0;
      org_y                = '0;
      org_z                = '0;
      dwell_cnt            = '0;
      tick_results_q.delete();
      pending_o    <= 0;
      fail_count_o <= n_fail;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_DIRECTION_LEFT:   cfg.direction_left   = cfg_data_i[0];
          REG_DISTANCE_LIMIT:   cfg.distance_limit   = cfg_data_i[DLIM_W-1:0];
          REG_FORCE_LIMIT:      cfg.force_limit      = cfg_data_i[FLIM_W-1:0];
          REG_WAIT_TICKS:       cfg.wait_ticks       = cfg_data_i[WT_W-1:0];
          REG_HOME_TOLERANCE:   cfg.home_tolerance   = cfg_data_i[TOL_W-1:0];
          REG_MAX_SPEED:        cfg.max_speed        = cfg_data_i[MSPD_W-1:0];
          REG_ZERO_SPEED_FORCE: cfg.zero_speed_force = cfg_data_i[ZF_W-1:0];
          default: ;
        endcase
      end

      if (out_valid_i && !out_stall_i) begin
        if (tick_results_q.size() == 0) begin
          $error("unexpected result: distance %0d speed_cmd %0d phase %0d",
                 distance_i, speed_cmd_i, phase_i);
          n_fail++;
        end else begin
          oldest = tick_results_q.pop_front();
          if (distance_i !== oldest.distance) begin
            $error("distance: expected %0d, actual %0d", oldest.distance, distance_i);
            n_fail++;
          end
          if (speed_cmd_i !== oldest.speed_cmd) begin
            $error("speed_cmd: expected %0d, actual %0d", oldest.speed_cmd, speed_cmd_i);
            n_fail++;
          end
          if (speed_cmd_sent_i !== oldest.sent) begin
            $error("speed_cmd_sent: expected %0d, actual %0d", oldest.sent,
                   speed_cmd_sent_i);
            n_fail++;
          end
          if (phase_i !== oldest.phase) begin
            $error("phase: expected %0d, actual %0d", oldest.phase, phase_i);
            n_fail++;
          end
        end
      end

      if (in_valid_i && !in_stall_i && pose_valid_i) begin
        tick_results_q.push_back(predict_tick(pos_x_i, pos_y_i, pos_z_i,
                                              force_x_i, force_y_i, force_z_i));
      end

      pending_o    <= tick_results_q.size();
      fail_count_o <= n_fail;
    end
  end

endmodule

### verif/testbench.sv
// Top of the stroke sequencer testbench: clock, reset, stimulus through one
// full forward/wait/return/stop run, and the verdict.
// Depends on flss_pkg, force_limited_stroke_sequencer_core and flss_checker.
module testbench;
  import flss_pkg::*;

  localparam int IDLE_LIMIT = 4000;
  localparam int SETTLE_CYC = 50;
  localparam int ORG        = -32768;

  logic                          clk        = 1'b0;
  logic                          rst_n      = 1'b0;
  logic                          cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]          cfg_idx    = REG_DIRECTION_LEFT;
  logic [CFG_DATA_W-1:0]         cfg_data   = '0;
  logic                          in_valid   = 1'b0;
  logic                          in_stall;
  logic                          pose_valid = 1'b0;
  logic signed [POS_WIDTH-1:0]   pos_x      = '0;
  logic signed [POS_WIDTH-1:0]   pos_y      = '0;
  logic signed [POS_WIDTH-1:0]   pos_z      = '0;
  logic signed [FORCE_WIDTH-1:0] force_x    = '0;
  logic signed [FORCE_WIDTH-1:0] force_y    = '0;
  logic signed [FORCE_WIDTH-1:0] force_z    = '0;
  logic                          out_valid;
  logic                          out_stall  = 1'b0;
  logic [DIST_W-1:0]             distance;
  logic signed [SPD_W-1:0]       speed_cmd;
  logic                          speed_cmd_sent;
  logic [PHASE_W-1:0]            phase;
  int                            fail_count;
  int                            pending;

  int burst_left  = 0;
  int stall_mode  = 0;
  int stall_left  = 0;
  int quiet_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  force_limited_stroke_sequencer_core u_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .pose_valid_i     (pose_valid),
    .pos_x_i          (pos_x),
    .pos_y_i          (pos_y),
    .pos_z_i          (pos_z),
    .force_x_i        (force_x),
    .force_y_i        (force_y),
    .force_z_i        (force_z),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .distance_o       (distance),
    .speed_cmd_o      (speed_cmd),
    .speed_cmd_sent_o (speed_cmd_sent),
    .phase_o          (phase)
  );

  flss_checker u_chk (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .pose_valid_i     (pose_valid),
    .pos_x_i          (pos_x),
    .pos_y_i          (pos_y),
    .pos_z_i          (pos_z),
    .force_x_i        (force_x),
    .force_y_i        (force_y),
    .force_z_i        (force_z),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .distance_i       (distance),
    .speed_cmd_i      (speed_cmd),
    .speed_cmd_sent_i (speed_cmd_sent),
    .phase_i          (phase),
    .fail_count_o     (fail_count),
    .pending_o        (pending)
  );

  // receiver: free-running, 50% stall, and heavy stall stretches
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(20, 300);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= $urandom_range(0, 1);
      default: out_stall <= ($urandom_range(0, 7) != 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles == IDLE_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  function automatic logic [POS_WIDTH-1:0] any_pos();
    logic [31:0] t;
    t = $urandom;
    return t[POS_WIDTH-1:0];
  endfunction

  function automatic logic [FORCE_WIDTH-1:0] any_force();
    logic [31:0] t;
    t = $urandom;
    return t[FORCE_WIDTH-1:0];
  endfunction

  // keeps every offset from the corner origin small enough that the
  // distance stays below the widest distance limit
  function automatic logic [POS_WIDTH-1:0] near_pos();
    logic [31:0] t;
    t = ORG + $urandom_range(0, 37000);
    return t[POS_WIDTH-1:0];
  endfunction

  // never the most negative code, which alone trips the widest force limit
  function automatic logic [FORCE_WIDTH-1:0] fwd_force();
    logic [31:0] t;
    if ($urandom_range(0, 1)) t = int'($urandom_range(0, 4000)) - 2000;
    else t = int'($urandom_range(0, 65534)) - 32767;
    return t[FORCE_WIDTH-1:0];
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  task automatic send_tick(input logic pv,
                           input logic signed [POS_WIDTH-1:0] px, py, pz,
                           input logic signed [FORCE_WIDTH-1:0] fx, fy, fz);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 60);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 150)
                                                : $urandom_range(1, 8);
    end
    burst_left--;
    in_valid   <= 1'b1;
    pose_valid <= pv;
    pos_x      <= px;
    pos_y      <= py;
    pos_z      <= pz;
    force_x    <= fx;
    force_y    <= fy;
    force_z    <= fz;
    do @(posedge clk); while (in_stall);
  endtask

  // occasional ignored tick with arbitrary content ahead of a valid one
  task automatic stroke_tick(input logic signed [POS_WIDTH-1:0] px, py, pz,
                             input logic signed [FORCE_WIDTH-1:0] fx, fy, fz);
    if ($urandom_range(0, 9) == 0) begin
      send_tick(1'b0, any_pos(), any_pos(), any_pos(),
                any_force(), any_force(), any_force());
    end
    send_tick(1'b1, px, py, pz, fx, fy, fz);
  endtask

  task automatic settle();
    in_valid   <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  initial begin
    int s, k;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings; ignored tick before the start point is latched
    send_tick(1'b0, any_pos(), any_pos(), any_pos(), any_force(), any_force(), any_force());
    send_tick(1'b1, ORG, ORG, ORG, 0, 0, 0);
    send_tick(1'b1, ORG + 1000, ORG, ORG, 600, 0, 0);
    send_tick(1'b1, ORG + 1732, ORG + 1732, ORG + 1732, -600, 600, -600);
    send_tick(1'b0, 32767, 32767, 32767, -32768, -32768, -32768);
    send_tick(1'b1, ORG + 2000, ORG, ORG, 0, -599, 0);
    settle();

    write_reg(REG_DIRECTION_LEFT, 1);
    write_reg(REG_DISTANCE_LIMIT, 65535);
    write_reg(REG_FORCE_LIMIT, 32767);
    write_reg(REG_WAIT_TICKS, 65535);
    write_reg(REG_HOME_TOLERANCE, 0);
    write_reg(REG_MAX_SPEED, 32767);
    write_reg(REG_ZERO_SPEED_FORCE, 65535);
    send_tick(1'b1, ORG, ORG, ORG, 32767, 32767, 32767);
    send_tick(1'b1, 4232, 4232, ORG, 0, 0, 0);
    send_tick(1'b1, 0, 0, 0, -32767, -32767, -32767);
    send_tick(1'b1, 0, ORG, 0, -1, 0, 0);
    settle();

    write_reg(REG_ZERO_SPEED_FORCE, 0);
    write_reg(REG_DIRECTION_LEFT, 0);
    send_tick(1'b1, ORG, 0, ORG, 32767, 32767, 0);
    send_tick(1'b1, ORG, ORG, 0, 0, 0, 0);
    send_tick(1'b1, 0, ORG, ORG, 1, 0, 0);
    settle();

    write_reg(REG_DIRECTION_LEFT, 1);
    send_tick(1'b1, ORG + 5, ORG, ORG, 32767, -32767, 5);
    settle();

    // just below the distance limit and exactly at the force limit
    write_reg(REG_DISTANCE_LIMIT, 1000);
    write_reg(REG_FORCE_LIMIT, 600);
    send_tick(1'b1, ORG + 999, ORG, ORG, -600, 600, 600);
    send_tick(1'b1, ORG, ORG + 999, ORG, 600, -600, -600);
    settle();
    write_reg(REG_DISTANCE_LIMIT, 65535);
    write_reg(REG_FORCE_LIMIT, 32767);

    // forward stroke under several speed laws
    for (s = 0; s < 5; s++) begin
      settle();
      case (s)
        0: begin
          write_reg(REG_DIRECTION_LEFT, 0);
          write_reg(REG_MAX_SPEED, 1000);
          write_reg(REG_ZERO_SPEED_FORCE, 600);
        end
        1: begin
          write_reg(REG_DIRECTION_LEFT, 1);
          write_reg(REG_MAX_SPEED, 32767);
          write_reg(REG_ZERO_SPEED_FORCE, 65535);
        end
        2: begin
          write_reg(REG_DIRECTION_LEFT, 0);
          write_reg(REG_ZERO_SPEED_FORCE, 0);
        end
        3: begin
          write_reg(REG_DIRECTION_LEFT, 1);
          write_reg(REG_MAX_SPEED, 0);
          write_reg(REG_ZERO_SPEED_FORCE, 1);
        end
        default: begin
          write_reg(REG_DIRECTION_LEFT, $urandom_range(0, 1));
          write_reg(REG_MAX_SPEED, $urandom_range(0, 32767));
          write_reg(REG_ZERO_SPEED_FORCE, $urandom_range(1, 65535));
        end
      endcase
      for (k = 0; k < 75; k++) begin
        stroke_tick(near_pos(), near_pos(), near_pos(), fwd_force(), fwd_force(),
                    fwd_force());
      end
    end
    settle();

    // stroke ends on the z force alone
    write_reg(REG_FORCE_LIMIT, 0);
    send_tick(1'b1, near_pos(), near_pos(), near_pos(), 0, 0, 1);

    for (k = 0; k < 40; k++) begin
      stroke_tick(any_pos(), any_pos(), any_pos(), any_force(), any_force(), any_force());
    end
    settle();
    // dwell count is 40 here; return starts on exactly the 45th waiting tick
    write_reg(REG_WAIT_TICKS, 45);
    write_reg(REG_DISTANCE_LIMIT, 0);
    write_reg(REG_FORCE_LIMIT, $urandom_range(0, 32767));
    for (k = 0; k < 5; k++) begin
      stroke_tick(any_pos(), any_pos(), any_pos(), any_force(), any_force(), any_force());
    end

    // returning with a zero tolerance never reaches home
    for (s = 0; s < 2; s++) begin
      settle();
      write_reg(REG_DIRECTION_LEFT, s);
      write_reg(REG_MAX_SPEED, (s == 1) ? 32767 : $urandom_range(0, 32767));
      write_reg(REG_ZERO_SPEED_FORCE, (s == 1) ? $urandom_range(1, 3000)
                                                : $urandom_range(0, 65535));
      write_reg(REG_WAIT_TICKS, 0);
      for (k = 0; k < 110; k++) begin
        stroke_tick(any_pos(), any_pos(), any_pos(), any_force(), any_force(),
                    any_force());
      end
    end
    settle();

    write_reg(REG_HOME_TOLERANCE, 200);
    send_tick(1'b1, ORG + 200, ORG, ORG, any_force(), any_force(), any_force());
    send_tick(1'b1, ORG + 199, ORG + 199, ORG + 199, any_force(), any_force(),
              any_force());
    settle();

    write_reg(REG_HOME_TOLERANCE, 32767);
    write_reg(REG_DIRECTION_LEFT, 0);
    write_reg(REG_MAX_SPEED, $urandom_range(0, 32767));
    write_reg(REG_ZERO_SPEED_FORCE, $urandom_range(0, 65535));
    write_reg(REG_DISTANCE_LIMIT, $urandom_range(0, 65535));
    send_tick(1'b1, 32767, 32767, 32767, 32767, -32768, 0);
    for (k = 0; k < 130; k++) begin
      stroke_tick(any_pos(), any_pos(), any_pos(), any_force(), any_force(), any_force());
    end
    settle();

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
